// File: hdl/sqt_pkg.sv
// shared types, constants and the sine table builder for the sprite quad transform
package sqt_pkg;

  // quarter-wave sine table
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int ROM_AW             = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int FRAC_W             = 14;
  localparam int IDX_PROD_W         = FRAC_W + $clog2(SINE_TABLE_ENTRIES) + 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // texture coordinate dividers
  localparam int NUM_DIV    = 4;
  localparam int DIVIDEND_W = 27;
  localparam int DIVISOR_W  = 13;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS;
  localparam int NUM_STAGES = DIV_STAGES;

  // divider slots
  localparam int DIV_UL = 0;
  localparam int DIV_UR = 1;
  localparam int DIV_VT = 2;
  localparam int DIV_VB = 3;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef logic [14:0] sine_rom_t [SINE_TABLE_ENTRIES + 1];

  typedef struct packed {
    logic [NUM_DIV-1:0][DIVIDEND_W-1:0] num;
    logic [NUM_DIV-1:0][DIVISOR_W-1:0]  rem;
    logic [NUM_DIV-1:0][DIVIDEND_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [15:0]      px;
    logic signed [15:0]      py;
    logic [31:0]             ew;
    logic [31:0]             eh;
    logic                    sin_neg;
    logic                    cos_neg;
    logic signed [47:0]      pa;
    logic signed [47:0]      pb;
    logic signed [47:0]      pc;
    logic signed [47:0]      pd;
    logic signed [48:0]      sp;
    logic signed [48:0]      sq;
    logic signed [48:0]      sr;
    logic signed [48:0]      ss;
    logic [3:0][22:0]        rx;
    logic [3:0][22:0]        ry;
    logic [3:0][15:0]        ox;
    logic [3:0][15:0]        oy;
    div_t                    div;
    logic [DIVISOR_W-1:0]    tw;
    logic [DIVISOR_W-1:0]    th;
    logic [1:0]              flips;
    logic [31:0]             color;
  } stage_t;

  // sine series evaluated at elaboration, Q1.14 entries
  function automatic sine_rom_t sqt_build_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd32768) >>> 16;
      if (r > 64'sd16384) begin
        r = 64'sd16384;
      end
      rom[i] = r[14:0];
    end
    return rom;
  endfunction

endpackage

// File: hdl/sprite_quad_transform.sv
// top level of the sprite quad vertex generator
//
// One sprite request enters on the s_axis channel and leaves as four vertex
// requests on m_axis in the order top-left, top-right, bottom-right,
// bottom-left. tuser carries the corner, tlast marks the bottom-left vertex.
// Each vertex holds the rotated, scaled and offset position, the texture
// coordinate and the sprite color.
// A sprite passes through nine pipeline stages and one output register; its
// vertices then follow one a cycle while the receiver is ready. The sprite
// rate is set by the output channel, which takes the next sprite as the last
// vertex leaves; the pipeline itself takes a sprite every cycle unless stalled.
// The pipeline holds the sine rom read, the corner multiplies, rounding,
// saturation and the texture dividers, three quotient bits per stage.
// Reset clears all valid flags; no sprite is pending afterwards.
// When the receiver stalls, the output holds its vertex, the pipeline fills up
// and then s_axis_tready drops; nothing is lost or repeated.
module sprite_quad_transform
  import sqt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, quad_width, quad_height, src_left, src_top, rotation_angle,
  // magnify, flip_flags, tex_width, tex_height, vertex_color, zero fill
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // out_x, out_y, tex_u, tex_v, color_out
  output logic [1:0]   m_axis_tuser,  // corner
  output logic         m_axis_tlast   // last_corner
);

  stage_t                  in_stage;
  stage_t                  stage_in [NUM_STAGES];
  stage_t                  stage_d  [NUM_STAGES];
  stage_t                  pipe_q   [NUM_STAGES];
  div_t                    div_nxt  [NUM_STAGES];
  logic [NUM_STAGES-1:0]   vld_q;
  logic [NUM_STAGES-1:0]   vld_in;
  logic [NUM_STAGES:0]     rdy;
  logic [15:0]             ang;
  logic [15:0]             cang;
  logic [IDX_PROD_W-1:0]   sprod;
  logic [IDX_PROD_W-1:0]   cprod;
  logic [ROM_AW-1:0]       sidx;
  logic [ROM_AW-1:0]       cidx;
  logic [ROM_AW-1:0]       saddr;
  logic [ROM_AW-1:0]       caddr;
  logic [14:0]             sin_t;
  logic [14:0]             cos_t;
  logic [16:0]             right_edge;
  logic [16:0]             bottom_edge;

  function automatic logic [22:0] rnd27(input logic signed [49:0] v);
    logic signed [49:0] b;
    b = v + (50'sd1 <<< 26);
    return b[49:27];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'h7FFF;
    end
    if (v < -24'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // rom addresses from the angle
  assign ang   = s_axis_tdata[111:96];
  assign cang  = ang + 16'd16384;
  assign sprod = IDX_PROD_W'(ang[FRAC_W-1:0]) * IDX_PROD_W'(SINE_TABLE_ENTRIES);
  assign cprod = IDX_PROD_W'(cang[FRAC_W-1:0]) * IDX_PROD_W'(SINE_TABLE_ENTRIES);
  assign sidx  = ROM_AW'(sprod >> FRAC_W);
  assign cidx  = ROM_AW'(cprod >> FRAC_W);
  assign saddr = ang[14] ? ROM_AW'(SINE_TABLE_ENTRIES) - sidx : sidx;
  assign caddr = cang[14] ? ROM_AW'(SINE_TABLE_ENTRIES) - cidx : cidx;

  sqt_sine_rom u_rom (
    .clk_i      (clk_i),
    .en_i       (rdy[0]),
    .sin_addr_i (saddr),
    .cos_addr_i (caddr),
    .sin_o      (sin_t),
    .cos_o      (cos_t)
  );

  // unpack the sprite request
  assign right_edge  = {1'b0, s_axis_tdata[79:64]} + {1'b0, s_axis_tdata[47:32]};
  assign bottom_edge = {1'b0, s_axis_tdata[95:80]} + {1'b0, s_axis_tdata[63:48]};

  always_comb begin
    in_stage         = '0;
    in_stage.px      = s_axis_tdata[15:0];
    in_stage.py      = s_axis_tdata[31:16];
    in_stage.ew      = 32'(s_axis_tdata[47:32]) * 32'(s_axis_tdata[127:112]);
    in_stage.eh      = 32'(s_axis_tdata[63:48]) * 32'(s_axis_tdata[127:112]);
    in_stage.sin_neg = ang[15];
    in_stage.cos_neg = cang[15];
    in_stage.flips   = s_axis_tdata[129:128];
    in_stage.tw      = s_axis_tdata[142:130];
    in_stage.th      = s_axis_tdata[155:143];
    in_stage.color   = s_axis_tdata[187:156];
    in_stage.div.num[DIV_UL] = {1'b0, s_axis_tdata[79:64], 10'b0};
    in_stage.div.num[DIV_UR] = {right_edge, 10'b0};
    in_stage.div.num[DIV_VT] = {1'b0, s_axis_tdata[95:80], 10'b0};
    in_stage.div.num[DIV_VB] = {bottom_edge, 10'b0};
  end

  // pipeline stages
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign stage_in[k] = in_stage;
      assign vld_in[k]   = s_axis_tvalid;
    end else begin : g_next
      assign stage_in[k] = pipe_q[k-1];
      assign vld_in[k]   = vld_q[k-1];
    end

    sqt_div_stage u_div (
      .div_i (stage_in[k].div),
      .dsr_i ({stage_in[k].th, stage_in[k].th, stage_in[k].tw, stage_in[k].tw}),
      .div_o (div_nxt[k])
    );

    // per-stage position work
    always_comb begin
      logic signed [15:0] sv;
      logic signed [15:0] cv;
      logic signed [49:0] vp;
      logic signed [49:0] vq;
      logic signed [49:0] vr;
      logic signed [49:0] vs;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      stage_d[k]     = stage_in[k];
      stage_d[k].div = div_nxt[k];
      sv = stage_in[k].sin_neg ? -$signed({1'b0, sin_t}) : $signed({1'b0, sin_t});
      cv = stage_in[k].cos_neg ? -$signed({1'b0, cos_t}) : $signed({1'b0, cos_t});
      vp = 50'(stage_in[k].sp);
      vq = 50'(stage_in[k].sq);
      vr = 50'(stage_in[k].sr);
      vs = 50'(stage_in[k].ss);
      if (k == 1) begin
        stage_d[k].pa = 48'($signed({1'b0, stage_in[k].ew})) * 48'(cv);
        stage_d[k].pb = 48'($signed({1'b0, stage_in[k].eh})) * 48'(sv);
        stage_d[k].pc = 48'($signed({1'b0, stage_in[k].ew})) * 48'(sv);
        stage_d[k].pd = 48'($signed({1'b0, stage_in[k].eh})) * 48'(cv);
      end
      if (k == 2) begin
        stage_d[k].sp = 49'(stage_in[k].pa) - 49'(stage_in[k].pb);
        stage_d[k].sq = 49'(stage_in[k].pa) + 49'(stage_in[k].pb);
        stage_d[k].sr = 49'(stage_in[k].pc) + 49'(stage_in[k].pd);
        stage_d[k].ss = 49'(stage_in[k].pc) - 49'(stage_in[k].pd);
      end
      if (k == 3) begin
        stage_d[k].rx[CORNER_TL] = rnd27(-vp);
        stage_d[k].rx[CORNER_TR] = rnd27(vq);
        stage_d[k].rx[CORNER_BR] = rnd27(vp);
        stage_d[k].rx[CORNER_BL] = rnd27(-vq);
        stage_d[k].ry[CORNER_TL] = rnd27(-vr);
        stage_d[k].ry[CORNER_TR] = rnd27(vs);
        stage_d[k].ry[CORNER_BR] = rnd27(vr);
        stage_d[k].ry[CORNER_BL] = rnd27(-vs);
      end
      if (k == 4) begin
        for (int c = 0; c < 4; c++) begin
          sx = 24'($signed(stage_in[k].rx[c])) + 24'(stage_in[k].px);
          sy = 24'($signed(stage_in[k].ry[c])) + 24'(stage_in[k].py);
          stage_d[k].ox[c] = sat16(sx);
          stage_d[k].oy[c] = sat16(sy);
        end
      end
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        pipe_q[k] <= stage_d[k];
      end
    end
  end

  assign s_axis_tready = rdy[0];

  sqt_corner_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_vld_i    (vld_q[NUM_STAGES-1]),
    .stage_i       (pipe_q[NUM_STAGES-1]),
    .rdy_o         (rdy[NUM_STAGES]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a finished sprite waiting on the output stays in the last stage
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NUM_STAGES-1] && !rdy[NUM_STAGES]) |=>
      (vld_q[NUM_STAGES-1] && $stable(pipe_q[NUM_STAGES-1].color)))
    else $error("finished sprite lost while output busy");

endmodule

// File: hdl/sqt_sine_rom.sv
// dual read port quarter-wave sine rom with registered outputs
module sqt_sine_rom
  import sqt_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ROM_AW-1:0] sin_addr_i,
  input  logic [ROM_AW-1:0] cos_addr_i,
  output logic [14:0]       sin_o,
  output logic [14:0]       cos_o
);

  localparam sine_rom_t ROM = sqt_build_rom();

  logic [14:0] sin_q;
  logic [14:0] cos_q;

  // registered reads, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= ROM[sin_addr_i];
      cos_q <= ROM[cos_addr_i];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: hdl/sqt_div_stage.sv
// a few restoring division steps for the four texture coordinate dividers
module sqt_div_stage
  import sqt_pkg::*;
(
  input  div_t                              div_i,
  input  logic [NUM_DIV-1:0][DIVISOR_W-1:0] dsr_i,
  output div_t                              div_o
);

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    logic [DIVISOR_W:0] r;
    logic               qbit;
    div_o = div_i;
    for (int d = 0; d < NUM_DIV; d++) begin
      for (int b = 0; b < DIV_BITS; b++) begin
        r    = {div_o.rem[d], div_o.num[d][DIVIDEND_W-1]};
        qbit = 1'b0;
        div_o.num[d] = {div_o.num[d][DIVIDEND_W-2:0], 1'b0};
        if (r >= {1'b0, dsr_i[d]}) begin
          r    = r - {1'b0, dsr_i[d]};
          qbit = 1'b1;
        end
        div_o.rem[d] = r[DIVISOR_W-1:0];
        div_o.quo[d] = {div_o.quo[d][DIVIDEND_W-2:0], qbit};
      end
    end
  end

endmodule

// File: hdl/sqt_corner_out.sv
// holds one finished sprite and sends its four vertices in corner order
module sqt_corner_out
  import sqt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_vld_i,
  input  stage_t      stage_i,
  output logic        rdy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // out_x, out_y, tex_u, tex_v, color_out
  output logic [1:0]  m_axis_tuser,  // corner
  output logic        m_axis_tlast   // last_corner
);

  logic             hold_q;
  corner_e          cnt_q;
  logic [3:0][15:0] ox_q;
  logic [3:0][15:0] oy_q;
  logic [15:0]      ul_q;
  logic [15:0]      ur_q;
  logic [15:0]      vt_q;
  logic [15:0]      vb_q;
  logic [31:0]      col_q;
  logic             take;
  logic             load;
  logic [15:0]      ul_d;
  logic [15:0]      ur_d;
  logic [15:0]      vt_d;
  logic [15:0]      vb_d;
  logic [15:0]      u_sel;
  logic [15:0]      v_sel;

  function automatic logic [15:0] sat_tex(input logic [DIVIDEND_W-1:0] q);
    if (q > DIVIDEND_W'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return q[15:0];
  endfunction

  // handshake with the pipeline and the receiver
  assign take  = hold_q && m_axis_tready && (cnt_q == CORNER_BL);
  assign rdy_o = !hold_q || take;
  assign load  = load_vld_i && rdy_o;

  // saturate texture coordinates and apply flips
  always_comb begin
    ul_d = sat_tex(stage_i.div.quo[DIV_UL]);
    ur_d = sat_tex(stage_i.div.quo[DIV_UR]);
    vt_d = sat_tex(stage_i.div.quo[DIV_VT]);
    vb_d = sat_tex(stage_i.div.quo[DIV_VB]);
    if (stage_i.flips[0]) begin
      ul_d = sat_tex(stage_i.div.quo[DIV_UR]);
      ur_d = sat_tex(stage_i.div.quo[DIV_UL]);
    end
    if (stage_i.flips[1]) begin
      vt_d = sat_tex(stage_i.div.quo[DIV_VB]);
      vb_d = sat_tex(stage_i.div.quo[DIV_VT]);
    end
  end

  // corner counter and hold flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      cnt_q  <= CORNER_TL;
    end else if (load) begin
      hold_q <= 1'b1;
      cnt_q  <= CORNER_TL;
    end else if (take) begin
      hold_q <= 1'b0;
    end else if (hold_q && m_axis_tready) begin
      cnt_q <= corner_e'(cnt_q + 2'd1);
    end
  end

  // vertex payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ox_q  <= stage_i.ox;
      oy_q  <= stage_i.oy;
      ul_q  <= ul_d;
      ur_q  <= ur_d;
      vt_q  <= vt_d;
      vb_q  <= vb_d;
      col_q <= stage_i.color;
    end
  end

  assign u_sel = (cnt_q == CORNER_TL || cnt_q == CORNER_BL) ? ul_q : ur_q;
  assign v_sel = (cnt_q == CORNER_TL || cnt_q == CORNER_TR) ? vt_q : vb_q;

  assign m_axis_tvalid = hold_q;
  assign m_axis_tdata  = {col_q, v_sel, u_sel, oy_q[cnt_q], ox_q[cnt_q]};
  assign m_axis_tuser  = cnt_q;
  assign m_axis_tlast  = (cnt_q == CORNER_BL);

  // a stalled vertex keeps its corner
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q && !m_axis_tready) |=> (hold_q && $stable(cnt_q)))
    else $error("corner changed while stalled");

  // after the last corner the next vertex starts a new sprite
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!hold_q || cnt_q == CORNER_TL))
    else $error("sprite did not restart at top-left");

endmodule

// File: verif/sprite_quad_transform_test.sv
// self-checking testbench for the sprite quad vertex generator
`timescale 1ns / 1ps

module sprite_quad_transform_test;
  import sqt_pkg::*;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        quad_w;
    logic [15:0]        quad_h;
    logic [15:0]        src_left;
    logic [15:0]        src_top;
    logic [15:0]        angle;
    logic [15:0]        magnify;
    logic [1:0]         flips;
    logic [12:0]        tex_w;
    logic [12:0]        tex_h;
    logic [31:0]        color;
  } sprite_t;

  typedef struct {
    corner_e            corner;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        color;
    logic               last;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  vertex_t expected_vertices[$];
  int          mismatch_count = 0;
  int          hold_off_cycles = 0;
  bit          sink_hold = 1'b0;
  int          sine_lut[SINE_TABLE_ENTRIES + 1];

  sprite_quad_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // quarter-wave table from the truncated taylor series
  function automatic int series_sine(int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          r;
    x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + 32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return int'(r);
  endfunction

  function automatic longint angle_sine(logic [15:0] a);
    int idx;
    int v;
    idx = (int'(a[13:0]) * SINE_TABLE_ENTRIES) >> 14;
    v   = a[14] ? sine_lut[SINE_TABLE_ENTRIES - idx] : sine_lut[idx];
    return a[15] ? -longint'(v) : longint'(v);
  endfunction

  // round to nearest over 27 bits, ties toward +inf
  function automatic longint round_q27(longint v);
    longint b;
    b = v + (longint'(1) << 26);
    if (b >= 0) begin
      return b >>> 27;
    end
    return -(((-b) + ((longint'(1) << 27) - 1)) >>> 27);
  endfunction

  function automatic logic [15:0] clamp_s16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] texel_coord(longint unsigned edge_pos,
                                              logic [12:0] size);
    longint unsigned q;
    if (size == 0) begin
      return 16'hffff;
    end
    q = (edge_pos << 10) / size;
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  // four corner vertices of one sprite
  task automatic predict_corners(sprite_t sp);
    longint          ext_w;
    longint          ext_h;
    longint          sn;
    longint          cs;
    longint          dx;
    longint          dy;
    logic [15:0]     ul;
    logic [15:0]     ur;
    logic [15:0]     vt;
    logic [15:0]     vb;
    logic [15:0]     tmp;
    vertex_t         vx;
    ext_w = longint'(sp.quad_w) * longint'(sp.magnify);
    ext_h = longint'(sp.quad_h) * longint'(sp.magnify);
    sn = angle_sine(sp.angle);
    cs = angle_sine(sp.angle + 16'd16384);
    ul = texel_coord(sp.src_left, sp.tex_w);
    ur = texel_coord(longint'(sp.src_left) + sp.quad_w, sp.tex_w);
    vt = texel_coord(sp.src_top, sp.tex_h);
    vb = texel_coord(longint'(sp.src_top) + sp.quad_h, sp.tex_h);
    if (sp.flips[0]) begin
      tmp = ul; ul = ur; ur = tmp;
    end
    if (sp.flips[1]) begin
      tmp = vt; vt = vb; vb = tmp;
    end
    for (int k = 0; k < 4; k++) begin
      dx = (k == 0 || k == 3) ? -ext_w : ext_w;
      dy = (k < 2) ? -ext_h : ext_h;
      vx.corner = corner_e'(k);
      vx.out_x  = clamp_s16(round_q27(dx * cs - dy * sn) + sp.pos_x);
      vx.out_y  = clamp_s16(round_q27(dx * sn + dy * cs) + sp.pos_y);
      vx.tex_u  = (k == 0 || k == 3) ? ul : ur;
      vx.tex_v  = (k < 2) ? vt : vb;
      vx.color  = sp.color;
      vx.last   = (k == 3);
      expected_vertices.push_back(vx);
    end
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // send one sprite request, gaps optional; valid stays high until the next gap or drain
  task automatic send_sprite(sprite_t sp, bit gaps);
    int gap;
    gap = gaps ? short_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, sp.color, sp.tex_h, sp.tex_w, sp.flips, sp.magnify,
                      sp.angle, sp.src_top, sp.src_left, sp.quad_h, sp.quad_w,
                      sp.pos_y, sp.pos_x};
    predict_corners(sp);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic sprite_t random_sprite();
    sprite_t sp;
    sp.pos_x    = 16'($urandom);
    sp.pos_y    = 16'($urandom);
    sp.quad_w   = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2048));
    sp.quad_h   = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2048));
    sp.src_left = 16'($urandom);
    sp.src_top  = 16'($urandom);
    sp.angle    = 16'($urandom);
    sp.magnify  = 16'($urandom);
    sp.flips    = 2'($urandom);
    sp.tex_w    = 13'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 4096));
    sp.tex_h    = 13'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 4096));
    sp.color    = $urandom;
    return sp;
  endfunction

  task automatic drain_vertices();
    s_axis_tvalid <= 1'b0;
    wait (expected_vertices.size() == 0);
    @(posedge clk_i);
  endtask

  // extremes, flips, quadrants, zero and oversize texture sizes
  task automatic test_directed();
    sprite_t sp;
    sp = '{16'sd0, 16'sd0, 16'd256, 16'd128, 16'd0, 16'd0, 16'd0, 16'd4096,
           2'd0, 13'd64, 13'd64, 32'hff00ff00};
    for (int i = 0; i < 4; i++) begin
      sp.flips = 2'(i);
      sp.angle = 16'(i * 16384);
      send_sprite(sp, 1'b0);
    end
    sp.angle = 16'd8192;
    send_sprite(sp, 1'b0);
    sp.angle = 16'hffff;
    send_sprite(sp, 1'b0);
    sp = '{16'sh7fff, 16'sh8000, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
           16'd100, 16'hffff, 2'd3, 13'd1, 13'd1, 32'hffffffff};
    send_sprite(sp, 1'b0);
    sp.pos_x = 16'sh8000; sp.pos_y = 16'sh7fff;
    sp.tex_w = 13'd0; sp.tex_h = 13'd0;
    send_sprite(sp, 1'b0);
    sp.tex_w = 13'h1fff; sp.tex_h = 13'd4096; sp.magnify = 16'd0;
    send_sprite(sp, 1'b0);
    sp = '{16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
           2'd0, 13'd4096, 13'd1, 32'd0};
    send_sprite(sp, 1'b0);
    sp.quad_w = 16'd1; sp.quad_h = 16'd1; sp.magnify = 16'd4096; sp.angle = 16'd16384;
    send_sprite(sp, 1'b0);
    drain_vertices();
  endtask

  // receiver stalls long while sprites keep coming
  task automatic test_backpressure();
    hold_off_cycles = 200;
    for (int i = 0; i < 20; i++) begin
      send_sprite(random_sprite(), 1'b0);
    end
    drain_vertices();
  endtask

  task automatic test_random();
    for (int i = 0; i < 340; i++) begin
      send_sprite(random_sprite(), 1'b1);
      if (i == 170) begin
        drain_vertices();
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // receiver ready with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 40) != 0);
    end
  end

  // compare each accepted vertex with the oldest prediction
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", m_axis_tdata[31:0], 0);
      end else begin
        want = expected_vertices.pop_front();
        if (m_axis_tuser != want.corner) report_mismatch("corner", m_axis_tuser, want.corner);
        if (m_axis_tdata[15:0] != want.out_x) report_mismatch("out_x", m_axis_tdata[15:0], want.out_x);
        if (m_axis_tdata[31:16] != want.out_y) report_mismatch("out_y", m_axis_tdata[31:16], want.out_y);
        if (m_axis_tdata[47:32] != want.tex_u) report_mismatch("tex_u", m_axis_tdata[47:32], want.tex_u);
        if (m_axis_tdata[63:48] != want.tex_v) report_mismatch("tex_v", m_axis_tdata[63:48], want.tex_v);
        if (m_axis_tdata[95:64] != want.color) report_mismatch("color", m_axis_tdata[95:64], want.color);
        if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      sine_lut[i] = series_sine(i);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    drain_vertices();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_vertices.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
